>>> rtl/glos_pkg.sv
package glos_pkg;

    // Default grid size
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int DIM_W     = 9;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    // Line tracer widths: absolute deltas, doubled deltas, error term,
    // and coordinates that carry a rectangle offset.
    localparam int DELTA_W  = 16;
    localparam int DD_W     = 17;
    localparam int ERR_W    = 20;
    localparam int FCOORD_W = 18;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] MAP_DIM_RESET = 9'd256;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_FILL,
        S_SETUP,
        S_STEP,
        S_MINOR,
        S_PRB_C,
        S_PRB_R,
        S_PRB_M,
        S_CHECK
    } state_t;

    // Which cell the shared address unit looks at
    typedef enum logic [1:0] {
        SEL_MAIN,
        SEL_SIDE_C,
        SEL_SIDE_R,
        SEL_FILL
    } cell_sel_t;

    typedef struct packed {
        logic      load;
        logic      setup;
        logic      probe;
        logic      write;
        logic      clear_wr;
        logic      fill_adv;
        logic      step;
        logic      minor;
        logic      end_step;
        logic      res_clear;
        logic      res_hit;
        cell_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fill_empty;
        logic            fill_last;
        logic            clr_last;
        logic            cnt_zero;
        logic            diag;
        logic            need_c;
        logic            need_r;
        logic            hit_now;
    } dp_status_t;

endpackage

>>> rtl/glos_ctrl.sv
module glos_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  glos_pkg::dp_status_t status,
    output glos_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    glos_pkg::state_t state_reg;
    glos_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    // State and result strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= glos_pkg::S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.sel    = glos_pkg::SEL_MAIN;
        state_next = state_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            glos_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = glos_pkg::S_IDLE;
                end
            end

            glos_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = glos_pkg::S_DECODE;
                end
            end

            glos_pkg::S_DECODE:
            begin
                unique case (status.op)
                    glos_pkg::OP_WRITE:
                    begin
                        state_next = glos_pkg::S_WRITE;
                    end
                    glos_pkg::OP_FILL:
                    begin
                        if (status.fill_empty)
                        begin
                            cmd.res_clear = 1'b1;
                            done_next     = 1'b1;
                            state_next    = glos_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = glos_pkg::S_FILL;
                        end
                    end
                    glos_pkg::OP_QUERY:
                    begin
                        state_next = glos_pkg::S_SETUP;
                    end
                    default:
                    begin
                        cmd.res_clear = 1'b1;
                        done_next     = 1'b1;
                        state_next    = glos_pkg::S_IDLE;
                    end
                endcase
            end

            glos_pkg::S_WRITE:
            begin
                cmd.write     = 1'b1;
                cmd.sel       = glos_pkg::SEL_MAIN;
                cmd.res_clear = 1'b1;
                done_next     = 1'b1;
                state_next    = glos_pkg::S_IDLE;
            end

            glos_pkg::S_FILL:
            begin
                cmd.write    = 1'b1;
                cmd.sel      = glos_pkg::SEL_FILL;
                cmd.fill_adv = 1'b1;
                if (status.fill_last)
                begin
                    cmd.res_clear = 1'b1;
                    done_next     = 1'b1;
                    state_next    = glos_pkg::S_IDLE;
                end
            end

            // Deltas and error term; the start cell is tested here.
            glos_pkg::S_SETUP:
            begin
                cmd.setup  = 1'b1;
                cmd.probe  = 1'b1;
                cmd.sel    = glos_pkg::SEL_MAIN;
                state_next = glos_pkg::S_STEP;
            end

            glos_pkg::S_STEP:
            begin
                if (status.cnt_zero)
                begin
                    cmd.res_clear = 1'b1;
                    done_next     = 1'b1;
                    state_next    = glos_pkg::S_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = glos_pkg::S_MINOR;
                end
            end

            glos_pkg::S_MINOR:
            begin
                cmd.minor = 1'b1;
                if (status.diag)
                begin
                    state_next = glos_pkg::S_PRB_C;
                end
                else
                begin
                    state_next = glos_pkg::S_PRB_M;
                end
            end

            glos_pkg::S_PRB_C:
            begin
                cmd.probe  = status.need_c;
                cmd.sel    = glos_pkg::SEL_SIDE_C;
                state_next = glos_pkg::S_PRB_R;
            end

            glos_pkg::S_PRB_R:
            begin
                cmd.probe  = status.need_r;
                cmd.sel    = glos_pkg::SEL_SIDE_R;
                state_next = glos_pkg::S_PRB_M;
            end

            glos_pkg::S_PRB_M:
            begin
                cmd.probe  = 1'b1;
                cmd.sel    = glos_pkg::SEL_MAIN;
                state_next = glos_pkg::S_CHECK;
            end

            glos_pkg::S_CHECK:
            begin
                if (status.hit_now)
                begin
                    cmd.res_hit = 1'b1;
                    done_next   = 1'b1;
                    state_next  = glos_pkg::S_IDLE;
                end
                else
                begin
                    cmd.end_step = 1'b1;
                    state_next   = glos_pkg::S_STEP;
                end
            end

            default:
            begin
                state_next = glos_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != glos_pkg::S_IDLE);
    assign done = done_reg;

endmodule

>>> rtl/glos_datapath.sv
module glos_datapath #(
    parameter int MAX_COLS = glos_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = glos_pkg::MAX_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [glos_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [glos_pkg::DIM_W-1:0]         cfg_data,
    input  logic [glos_pkg::OP_W-1:0]          operation,
    input  logic [glos_pkg::COORD_W-1:0]       col_a,
    input  logic [glos_pkg::COORD_W-1:0]       row_a,
    input  logic [glos_pkg::COORD_W-1:0]       col_b,
    input  logic [glos_pkg::COORD_W-1:0]       row_b,
    input  logic [glos_pkg::DIM_W-1:0]         rect_cols,
    input  logic [glos_pkg::DIM_W-1:0]         rect_rows,
    input  logic                               cell_value,
    input  glos_pkg::dp_cmd_t                  cmd,
    output glos_pkg::dp_status_t               status,
    output logic                               blocked,
    output logic [glos_pkg::COORD_W-1:0]       hit_col,
    output logic [glos_pkg::COORD_W-1:0]       hit_row
);

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int MUL_W      = ADDR_W + 1;
    localparam int CW         = glos_pkg::COORD_W;
    localparam int FW         = glos_pkg::FCOORD_W;
    localparam int EW         = glos_pkg::ERR_W;
    localparam int DW         = glos_pkg::DIM_W;

    localparam logic [CW-1:0]     MAX_COLS_C = CW'(MAX_COLS);
    localparam logic [CW-1:0]     MAX_ROWS_C = CW'(MAX_ROWS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(GRID_DEPTH - 1);
    localparam logic [CW-1:0]     ONE_C      = CW'(1);
    localparam logic [CW-1:0]     MINUS_ONE  = '1;

    // Configuration and control registers
    logic [DW-1:0]     map_width_reg;
    logic [DW-1:0]     map_height_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              pend_reg;
    logic              hit_reg;

    // Operation registers
    logic [glos_pkg::OP_W-1:0]    op_reg;
    logic [CW-1:0]                c_reg;
    logic [CW-1:0]                r_reg;
    logic [CW-1:0]                cb_reg;
    logic [CW-1:0]                rb_reg;
    logic [DW-1:0]                nc_reg;
    logic [DW-1:0]                nr_reg;
    logic                         v_reg;
    logic [DW-1:0]                i_reg;
    logic [DW-1:0]                j_reg;
    logic                         cs_reg;
    logic                         rs_reg;
    logic                         row_major_reg;
    logic [glos_pkg::DD_W-1:0]    dd_major_reg;
    logic [glos_pkg::DD_W-1:0]    dd_minor_reg;
    logic [EW-1:0]                err_reg;
    logic [EW-1:0]                prev_reg;
    logic [glos_pkg::DELTA_W-1:0] cnt_reg;
    logic                         need_c_reg;
    logic                         need_r_reg;
    logic                         in_grid_reg;
    logic                         rd_bit_reg;
    logic                         blocked_reg;
    logic [CW-1:0]                hit_col_reg;
    logic [CW-1:0]                hit_row_reg;

    logic grid_mem [GRID_DEPTH];

    // Neighbor coordinates along each axis
    logic [CW-1:0] c_fwd;
    logic [CW-1:0] c_back;
    logic [CW-1:0] r_fwd;
    logic [CW-1:0] r_back;

    assign c_fwd  = c_reg + (cs_reg ? MINUS_ONE : ONE_C);
    assign c_back = c_reg + (cs_reg ? ONE_C : MINUS_ONE);
    assign r_fwd  = r_reg + (rs_reg ? MINUS_ONE : ONE_C);
    assign r_back = r_reg + (rs_reg ? ONE_C : MINUS_ONE);

    // Cell selection for the shared address unit
    logic [FW-1:0] fcol;
    logic [FW-1:0] frow;

    always_comb
    begin
        unique case (cmd.sel)
            glos_pkg::SEL_MAIN:
            begin
                fcol = {{(FW-CW){c_reg[CW-1]}}, c_reg};
                frow = {{(FW-CW){r_reg[CW-1]}}, r_reg};
            end
            glos_pkg::SEL_SIDE_C:
            begin
                fcol = {{(FW-CW){c_back[CW-1]}}, c_back};
                frow = {{(FW-CW){r_reg[CW-1]}}, r_reg};
            end
            glos_pkg::SEL_SIDE_R:
            begin
                fcol = {{(FW-CW){c_reg[CW-1]}}, c_reg};
                frow = {{(FW-CW){r_back[CW-1]}}, r_back};
            end
            glos_pkg::SEL_FILL:
            begin
                fcol = {{(FW-CW){c_reg[CW-1]}}, c_reg} + FW'(i_reg);
                frow = {{(FW-CW){r_reg[CW-1]}}, r_reg} + FW'(j_reg);
            end
        endcase
    end

    // Grid bounds: the register value, capped at the storage size
    logic [CW-1:0] used_cols;
    logic [CW-1:0] used_rows;
    logic          in_grid;

    assign used_cols = (CW'(map_width_reg) > MAX_COLS_C) ? MAX_COLS_C : CW'(map_width_reg);
    assign used_rows = (CW'(map_height_reg) > MAX_ROWS_C) ? MAX_ROWS_C : CW'(map_height_reg);
    assign in_grid   = !fcol[FW-1] && !frow[FW-1]
                       && (fcol < FW'(used_cols)) && (frow < FW'(used_rows));

    // Row-major cell address
    logic [MUL_W-1:0]  addr_full;
    logic [ADDR_W-1:0] cell_addr;

    assign addr_full = MUL_W'(frow[ROW_W-1:0]) * MUL_W'(MAX_COLS) + MUL_W'(fcol[COL_W-1:0]);
    assign cell_addr = addr_full[ADDR_W-1:0];

    // Grid memory: one write and one registered read per cycle
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_bit;

    assign mem_we  = cmd.clear_wr | (cmd.write & in_grid);
    assign wr_addr = cmd.clear_wr ? clr_reg : cell_addr;
    assign wr_bit  = !cmd.clear_wr & v_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[wr_addr] <= wr_bit;
        end
        rd_bit_reg <= grid_mem[cell_addr];
    end

    logic probe_blk;
    assign probe_blk = !in_grid_reg | rd_bit_reg;

    // Line setup: absolute deltas and step directions
    logic [CW:0]                  dcol;
    logic [CW:0]                  drow;
    logic [CW:0]                  ncol;
    logic [CW:0]                  nrow;
    logic [glos_pkg::DELTA_W-1:0] abs_col;
    logic [glos_pkg::DELTA_W-1:0] abs_row;
    logic                         row_major;
    logic [glos_pkg::DELTA_W-1:0] len_major;
    logic [glos_pkg::DELTA_W-1:0] len_minor;

    assign dcol      = {cb_reg[CW-1], cb_reg} - {c_reg[CW-1], c_reg};
    assign drow      = {rb_reg[CW-1], rb_reg} - {r_reg[CW-1], r_reg};
    assign ncol      = '0 - dcol;
    assign nrow      = '0 - drow;
    assign abs_col   = dcol[CW] ? ncol[CW-1:0] : dcol[CW-1:0];
    assign abs_row   = drow[CW] ? nrow[CW-1:0] : drow[CW-1:0];
    assign row_major = (abs_row >= abs_col);
    assign len_major = row_major ? abs_row : abs_col;
    assign len_minor = row_major ? abs_col : abs_row;

    // Minor step test and side cell choice at a diagonal move
    logic          diag;
    logic [EW-1:0] side_sum;
    logic [EW-1:0] dd_major_x2;
    logic          side_lt;
    logic          side_gt;

    assign diag        = (err_reg > EW'(dd_major_reg));
    assign side_sum    = err_reg + prev_reg;
    assign dd_major_x2 = EW'({dd_major_reg, 1'b0});
    assign side_lt     = (side_sum < dd_major_x2);
    assign side_gt     = (side_sum > dd_major_x2);

    // Configuration, clearing sweep and probe bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= glos_pkg::MAP_DIM_RESET;
            map_height_reg <= glos_pkg::MAP_DIM_RESET;
            clr_reg        <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    glos_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    glos_pkg::CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            pend_reg <= cmd.probe;
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (pend_reg && probe_blk)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Operation operands, tracer state and result
    always_ff @(posedge clk)
    begin
        if (cmd.probe)
        begin
            in_grid_reg <= in_grid;
        end

        if (cmd.load)
        begin
            op_reg <= operation;
            c_reg  <= col_a;
            r_reg  <= row_a;
            cb_reg <= col_b;
            rb_reg <= row_b;
            nc_reg <= rect_cols;
            nr_reg <= rect_rows;
            v_reg  <= cell_value;
            i_reg  <= '0;
            j_reg  <= '0;
        end
        else if (cmd.fill_adv)
        begin
            if (j_reg == nr_reg - DW'(1))
            begin
                j_reg <= '0;
                i_reg <= i_reg + DW'(1);
            end
            else
            begin
                j_reg <= j_reg + DW'(1);
            end
        end

        if (cmd.setup)
        begin
            cs_reg        <= dcol[CW];
            rs_reg        <= drow[CW];
            row_major_reg <= row_major;
            dd_major_reg  <= {len_major, 1'b0};
            dd_minor_reg  <= {len_minor, 1'b0};
            err_reg       <= EW'(len_major);
            prev_reg      <= EW'(len_major);
            cnt_reg       <= len_major;
        end

        // Major axis move
        if (cmd.step)
        begin
            cnt_reg <= cnt_reg - glos_pkg::DELTA_W'(1);
            err_reg <= err_reg + EW'(dd_minor_reg);
            if (row_major_reg)
            begin
                r_reg <= r_fwd;
            end
            else
            begin
                c_reg <= c_fwd;
            end
        end

        // Minor axis move when the error term overflows
        if (cmd.minor && diag)
        begin
            err_reg <= err_reg - EW'(dd_major_reg);
            if (row_major_reg)
            begin
                c_reg      <= c_fwd;
                need_c_reg <= !side_gt;
                need_r_reg <= !side_lt;
            end
            else
            begin
                r_reg      <= r_fwd;
                need_c_reg <= !side_lt;
                need_r_reg <= !side_gt;
            end
        end

        if (cmd.end_step)
        begin
            prev_reg <= err_reg;
        end

        if (cmd.res_clear)
        begin
            blocked_reg <= 1'b0;
            hit_col_reg <= '0;
            hit_row_reg <= '0;
        end
        else if (cmd.res_hit)
        begin
            blocked_reg <= 1'b1;
            hit_col_reg <= c_reg;
            hit_row_reg <= r_reg;
        end
    end

    // Status toward the controller
    assign status.op         = op_reg;
    assign status.fill_empty = (nc_reg == '0) || (nr_reg == '0);
    assign status.fill_last  = (i_reg == nc_reg - DW'(1)) && (j_reg == nr_reg - DW'(1));
    assign status.clr_last   = (clr_reg == LAST_ADDR);
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.diag       = diag;
    assign status.need_c     = need_c_reg;
    assign status.need_r     = need_r_reg;
    assign status.hit_now    = hit_reg | (pend_reg & probe_blk);

    assign blocked = blocked_reg;
    assign hit_col = hit_col_reg;
    assign hit_row = hit_row_reg;

endmodule

>>> rtl/grid_line_of_sight.sv
// A cell write passes through the decode and write states and then gives done; a fill
// makes one grid memory write per cell, then gives done; an empty fill gives done from decode.
// A clear query walks the line to its end, probing the side cells of each diagonal step as
// needed; a blocked query gives done after the check of the step that meets the obstacle.
// One operation at a time: start is taken while busy is low, again in the cycle of done;
// done is a one-cycle strobe. After reset the grid is swept to free, with busy high.
module grid_line_of_sight #(
    parameter int MAX_COLS = glos_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = glos_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [glos_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [glos_pkg::DIM_W-1:0]     cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [glos_pkg::OP_W-1:0]      operation,
    input  logic [glos_pkg::COORD_W-1:0]   col_a,
    input  logic [glos_pkg::COORD_W-1:0]   row_a,
    input  logic [glos_pkg::COORD_W-1:0]   col_b,
    input  logic [glos_pkg::COORD_W-1:0]   row_b,
    input  logic [glos_pkg::DIM_W-1:0]     rect_cols,
    input  logic [glos_pkg::DIM_W-1:0]     rect_rows,
    input  logic                           cell_value,
    output logic                           done,
    output logic                           blocked,
    output logic [glos_pkg::COORD_W-1:0]   hit_col,
    output logic [glos_pkg::COORD_W-1:0]   hit_row
);

    glos_pkg::dp_cmd_t    cmd;
    glos_pkg::dp_status_t status;

    // Sequencer
    glos_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Grid memory, address unit and line tracer
    glos_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .operation  (operation),
        .col_a      (col_a),
        .row_a      (row_a),
        .col_b      (col_b),
        .row_b      (row_b),
        .rect_cols  (rect_cols),
        .rect_rows  (rect_rows),
        .cell_value (cell_value),
        .cmd        (cmd),
        .status     (status),
        .blocked    (blocked),
        .hit_col    (hit_col),
        .hit_row    (hit_row)
    );

    // A result transfer always lands with the sequencer back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // An accepted start always occupies the sequencer for the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start accepted but block not busy");

    // Each operation gives a single result strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A clear result carries zero hit coordinates.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !blocked) |-> (hit_col == '0 && hit_row == '0))
        else $error("clear result with nonzero hit coordinates");

    // The grid port never reads for a probe while it writes.
    a_probe_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.probe && (cmd.write || cmd.clear_wr)))
        else $error("probe and write issued together");

endmodule

>>> tb/tb_grid_line_of_sight.sv
module tb_grid_line_of_sight;
    import glos_pkg::*;

    // The block has no name for the spare operation code.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int GRID_COLS = MAX_COLS_DEF;
    localparam int GRID_ROWS = MAX_ROWS_DEF;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] ca;
        logic signed [COORD_W-1:0] ra;
        logic signed [COORD_W-1:0] cb;
        logic signed [COORD_W-1:0] rb;
        logic [DIM_W-1:0]          nc;
        logic [DIM_W-1:0]          nr;
        logic                      v;
    } grid_op_t;

    typedef struct {
        logic               hit;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } sight_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]   cfg_data;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_b;
    logic [COORD_W-1:0] row_b;
    logic [DIM_W-1:0]   rect_cols;
    logic [DIM_W-1:0]   rect_rows;
    logic               cell_value;
    logic               done;
    logic               blocked;
    logic [COORD_W-1:0] hit_col;
    logic [COORD_W-1:0] hit_row;

    // Shadow of the occupancy grid and of the map size registers.
    bit occupancy [0:GRID_COLS*GRID_ROWS-1];
    int map_cols_reg;
    int map_rows_reg;

    // Outcomes still owed by the block, oldest first.
    sight_result_t expected_outcomes [$];

    int  mismatches;
    bit  no_idle;
    int  n_writes;
    int  n_fills;
    int  n_queries;
    int  n_hits;
    int  n_unused;
    int  n_settings;

    grid_line_of_sight DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .col_a      (col_a),
        .row_a      (row_a),
        .col_b      (col_b),
        .row_b      (row_b),
        .rect_cols  (rect_cols),
        .rect_rows  (rect_rows),
        .cell_value (cell_value),
        .done       (done),
        .blocked    (blocked),
        .hit_col    (hit_col),
        .hit_row    (hit_row)
    );

    // Clock with a period of 10.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog for a hung block.
    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int cols_in_use();
        return (map_cols_reg > GRID_COLS) ? GRID_COLS : map_cols_reg;
    endfunction

    function automatic int rows_in_use();
        return (map_rows_reg > GRID_ROWS) ? GRID_ROWS : map_rows_reg;
    endfunction

    function automatic bit on_map(int c, int r);
        return c >= 0 && r >= 0 && c < cols_in_use() && r < rows_in_use();
    endfunction

    // Cells off the map in use count as obstacles.
    function automatic bit is_obstacle(int c, int r);
        if (!on_map(c, r))
            return 1'b1;
        return occupancy[r * GRID_COLS + c];
    endfunction

    function automatic void store_cell(int c, int r, bit v);
        if (on_map(c, r))
            occupancy[r * GRID_COLS + c] = v;
    endfunction

    // Supercover line walk: at a diagonal move the side cell or cells passed
    // are tested too, and the first step that meets an obstacle is reported.
    function automatic sight_result_t trace_sight(int c, int r, int c2, int r2);
        int dr;
        int dc;
        int rs;
        int cs;
        int ddr;
        int ddc;
        int err;
        int prev;
        bit hit;
        sight_result_t res;
        res = '{hit: 1'b0, col: '0, row: '0};
        dr = r2 - r;
        dc = c2 - c;
        rs = 1;
        cs = 1;
        hit = is_obstacle(c, r);
        if (dr < 0)
        begin
            rs = -1;
            dr = -dr;
        end
        if (dc < 0)
        begin
            cs = -1;
            dc = -dc;
        end
        ddr = 2 * dr;
        ddc = 2 * dc;
        if (ddr >= ddc)
        begin
            // Rows are the major axis.
            err = dr;
            prev = dr;
            for (int i = 0; i < dr; i++)
            begin
                r += rs;
                err += ddc;
                if (err > ddr)
                begin
                    c += cs;
                    err -= ddr;
                    if (err + prev < ddr)
                        hit = hit || is_obstacle(c - cs, r);
                    else if (err + prev > ddr)
                        hit = hit || is_obstacle(c, r - rs);
                    else
                        hit = hit || is_obstacle(c - cs, r) || is_obstacle(c, r - rs);
                end
                hit = hit || is_obstacle(c, r);
                prev = err;
                if (hit)
                begin
                    res.hit = 1'b1;
                    res.col = c[COORD_W-1:0];
                    res.row = r[COORD_W-1:0];
                    return res;
                end
            end
        end
        else
        begin
            // Columns are the major axis.
            err = dc;
            prev = dc;
            for (int i = 0; i < dc; i++)
            begin
                c += cs;
                err += ddr;
                if (err > ddc)
                begin
                    r += rs;
                    err -= ddc;
                    if (err + prev < ddc)
                        hit = hit || is_obstacle(c, r - rs);
                    else if (err + prev > ddc)
                        hit = hit || is_obstacle(c - cs, r);
                    else
                        hit = hit || is_obstacle(c, r - rs) || is_obstacle(c - cs, r);
                end
                hit = hit || is_obstacle(c, r);
                prev = err;
                if (hit)
                begin
                    res.hit = 1'b1;
                    res.col = c[COORD_W-1:0];
                    res.row = r[COORD_W-1:0];
                    return res;
                end
            end
        end
        return res;
    endfunction

    // Applies one operation to the shadow grid and returns the outcome owed.
    function automatic sight_result_t apply_grid_op(grid_op_t it);
        sight_result_t res;
        res = '{hit: 1'b0, col: '0, row: '0};
        case (it.op)
            OP_WRITE:
            begin
                n_writes++;
                store_cell(int'(it.ca), int'(it.ra), it.v);
            end
            OP_FILL:
            begin
                n_fills++;
                for (int i = 0; i < int'(it.nc); i++)
                    for (int j = 0; j < int'(it.nr); j++)
                        store_cell(int'(it.ca) + i, int'(it.ra) + j, it.v);
            end
            OP_QUERY:
            begin
                n_queries++;
                res = trace_sight(int'(it.ca), int'(it.ra), int'(it.cb), int'(it.rb));
                if (res.hit)
                    n_hits++;
            end
            default:
                n_unused++;
        endcase
        return res;
    endfunction

    // Result checker: every done strobe is matched with the oldest outcome owed.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: blocked=%0b col=%0d row=%0d",
                             $realtime, blocked, $signed(hit_col), $signed(hit_row));
            end
            else if (blocked !== expected_outcomes[0].hit ||
                     hit_col !== expected_outcomes[0].col ||
                     hit_row !== expected_outcomes[0].row)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected blocked=%0b col=%0d row=%0d, %s%0b %s%0d %s%0d",
                             $realtime, expected_outcomes[0].hit,
                             $signed(expected_outcomes[0].col),
                             $signed(expected_outcomes[0].row),
                             "got blocked=", blocked, "col=", $signed(hit_col),
                             "row=", $signed(hit_row));
                void'(expected_outcomes.pop_front());
            end
            else
            begin
                void'(expected_outcomes.pop_front());
            end
        end
    end

    // Mostly short gaps, a few long ones, none at all in a burst phase.
    function automatic int pick_gap();
        int k;
        if (no_idle)
            return 0;
        k = $urandom_range(99);
        if (k < 45)
            return 0;
        if (k < 85)
            return $urandom_range(3, 1);
        if (k < 97)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // Sends one operation and records its outcome once the transfer is taken.
    task automatic send_op(input grid_op_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation  = it.op;
        col_a      = it.ca;
        row_a      = it.ra;
        col_b      = it.cb;
        row_b      = it.rb;
        rect_cols  = it.nc;
        rect_rows  = it.nr;
        cell_value = it.v;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_outcomes.push_back(apply_grid_op(it));
    endtask

    // Holds off until every owed outcome has arrived and the block is quiet.
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val[DIM_W-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_MAP_WIDTH)
            map_cols_reg = val & 32'h1ff;
        else
            map_rows_reg = val & 32'h1ff;
    endtask

    task automatic set_map_size(input int w, input int h);
        set_register(CFG_MAP_WIDTH, w);
        set_register(CFG_MAP_HEIGHT, h);
        n_settings++;
    endtask

    function automatic grid_op_t make_op(logic [OP_W-1:0] op, int ca, int ra, int cb,
                                         int rb, int nc, int nr, bit v);
        grid_op_t it;
        it.op = op;
        it.ca = ca[COORD_W-1:0];
        it.ra = ra[COORD_W-1:0];
        it.cb = cb[COORD_W-1:0];
        it.rb = rb[COORD_W-1:0];
        it.nc = nc[DIM_W-1:0];
        it.nr = nr[DIM_W-1:0];
        it.v  = v;
        return it;
    endfunction

    // Coordinates mostly on or just around the map, some extremes, some anywhere.
    function automatic int rand_coord(int lim);
        int k;
        k = $urandom_range(99);
        if (k < 75)
            return int'($urandom_range(lim + 3)) - 2;
        if (k < 85)
        begin
            case ($urandom_range(4))
                0: return -32768;
                1: return 32767;
                2: return 0;
                3: return lim - 1;
                default: return lim;
            endcase
        end
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic grid_op_t random_op();
        grid_op_t it;
        int w;
        int h;
        int k;
        int ca;
        int ra;
        int cb;
        int rb;
        int nc;
        int nr;
        w = cols_in_use();
        h = rows_in_use();
        k = $urandom_range(99);
        ca = rand_coord(w);
        ra = rand_coord(h);
        cb = 0;
        rb = 0;
        nc = 0;
        nr = 0;
        if (k < 14)
        begin
            it = make_op(OP_WRITE, ca, ra, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(256), $urandom_range(256), $urandom_range(99) < 75);
        end
        else if (k < 24)
        begin
            // Fills: mostly small blocks, some long thin walls.
            k = $urandom_range(99);
            if (k < 65)
            begin
                nc = $urandom_range(8);
                nr = $urandom_range(8);
            end
            else if (k < 80)
            begin
                nc = $urandom_range(256);
                nr = $urandom_range(2, 1);
            end
            else if (k < 95)
            begin
                nc = $urandom_range(2, 1);
                nr = $urandom_range(256);
            end
            else
            begin
                nc = $urandom_range(32);
                nr = $urandom_range(32);
            end
            it = make_op(OP_FILL, ca, ra, $urandom_range(65535), $urandom_range(65535),
                         nc, nr, $urandom_range(1));
        end
        else if (k < 95)
        begin
            k = $urandom_range(99);
            if (k < 70)
            begin
                cb = rand_coord(w);
                rb = rand_coord(h);
            end
            else if (k < 90)
            begin
                cb = ca + int'($urandom_range(12)) - 6;
                rb = ra + int'($urandom_range(12)) - 6;
            end
            else
            begin
                cb = int'($urandom_range(65535)) - 32768;
                rb = int'($urandom_range(65535)) - 32768;
            end
            it = make_op(OP_QUERY, ca, ra, cb, rb, $urandom_range(256), $urandom_range(256),
                         $urandom_range(1));
        end
        else
        begin
            it = make_op(OP_UNUSED, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(256), $urandom_range(256), $urandom_range(1));
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_op(random_op());
    endtask

    // Reset, wait out the grid clearing sweep, then load the default map size.
    task automatic test_power_up();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        set_map_size(256, 256);
    endtask

    // Hand-picked operations for the corner cases of writes, fills and queries.
    task automatic test_directed_cases();
        send_op(make_op(OP_WRITE, 0, 0, 0, 0, 0, 0, 1'b1));
        // Blocked start cell is reported at the first step.
        send_op(make_op(OP_QUERY, 0, 0, 5, 5, 0, 0, 1'b0));
        // Zero-length line is clear even on an obstacle.
        send_op(make_op(OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b0));
        send_op(make_op(OP_WRITE, 255, 255, 0, 0, 0, 0, 1'b1));
        send_op(make_op(OP_QUERY, 250, 250, 255, 255, 0, 0, 1'b0));
        // Writes off the map are dropped.
        send_op(make_op(OP_WRITE, -1, 5, 0, 0, 0, 0, 1'b1));
        send_op(make_op(OP_WRITE, 256, 0, 0, 0, 0, 0, 1'b1));
        send_op(make_op(OP_WRITE, -32768, 32767, 0, 0, 0, 0, 1'b1));
        // Lines that run off the map edges and across the whole coordinate range.
        send_op(make_op(OP_QUERY, 10, 10, 10, -32768, 0, 0, 1'b0));
        send_op(make_op(OP_QUERY, 10, 10, 32767, 10, 0, 0, 1'b0));
        send_op(make_op(OP_QUERY, -32768, -32768, 32767, 32767, 0, 0, 1'b0));
        // Empty rectangles fill nothing.
        send_op(make_op(OP_FILL, 20, 20, 0, 0, 0, 5, 1'b1));
        send_op(make_op(OP_FILL, 20, 20, 0, 0, 5, 0, 1'b1));
        send_op(make_op(OP_FILL, 30, 30, 0, 0, 3, 3, 1'b1));
        send_op(make_op(OP_QUERY, 28, 31, 34, 31, 0, 0, 1'b0));
        send_op(make_op(OP_QUERY, 28, 28, 33, 32, 0, 0, 1'b0));
        // Exact diagonal squeezes between two side cells.
        send_op(make_op(OP_WRITE, 41, 40, 0, 0, 0, 0, 1'b1));
        send_op(make_op(OP_QUERY, 40, 40, 42, 42, 0, 0, 1'b0));
        send_op(make_op(OP_QUERY, 45, 38, 40, 43, 0, 0, 1'b0));
        send_op(make_op(OP_FILL, 30, 30, 0, 0, 3, 3, 1'b0));
        send_op(make_op(OP_UNUSED, 100, 100, 200, 200, 4, 4, 1'b1));
        // Map-sized rectangle, clipped at the map corner, then cleared again.
        send_op(make_op(OP_FILL, -5, -5, 0, 0, 256, 256, 1'b1));
        send_op(make_op(OP_QUERY, 100, 100, 100, 100, 0, 0, 1'b0));
        send_op(make_op(OP_QUERY, 252, 252, 240, 240, 0, 0, 1'b0));
        send_op(make_op(OP_FILL, 0, 0, 0, 0, 256, 256, 1'b0));
        send_op(make_op(OP_QUERY, 0, 0, 255, 200, 0, 0, 1'b0));
    endtask

    // Map sizes from the smallest to beyond the grid, with zero sizes as well.
    task automatic test_map_sizes();
        int widths [8] = '{8, 8, 256, 33, 511, 0, 40, 300};
        int heights [8] = '{1, 256, 1, 19, 511, 12, 0, 257};
        int counts [8] = '{40, 40, 40, 50, 40, 10, 10, 40};
        for (int s = 0; s < 8; s++)
        begin
            // The sender holds off here until every outcome has come.
            wait_idle();
            set_map_size(widths[s], heights[s]);
            no_idle = (s % 3 == 1);
            run_random(counts[s]);
        end
    endtask

    // Bulk traffic on the full map, with one stretch at full rate, then on a 200x150 map.
    task automatic test_random_traffic();
        wait_idle();
        set_map_size(256, 256);
        no_idle = 1'b0;
        run_random(500);
        no_idle = 1'b1;
        run_random(150);
        no_idle = 1'b0;
        wait_idle();
        set_map_size(200, 150);
        run_random(250);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_MAP_WIDTH;
        cfg_data   = '0;
        start      = 1'b0;
        operation  = OP_WRITE;
        col_a      = '0;
        row_a      = '0;
        col_b      = '0;
        row_b      = '0;
        rect_cols  = '0;
        rect_rows  = '0;
        cell_value = 1'b0;
        mismatches = 0;
        no_idle    = 1'b0;
        n_writes   = 0;
        n_fills    = 0;
        n_queries  = 0;
        n_hits     = 0;
        n_unused   = 0;
        n_settings = 0;
        map_cols_reg = 256;
        map_rows_reg = 256;
        foreach (occupancy[i])
            occupancy[i] = 1'b0;

        test_power_up();
        test_directed_cases();
        test_map_sizes();
        test_random_traffic();

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Run covered %0d cell writes, %0d fills, %0d sight queries (%0d blocked)",
                 n_writes, n_fills, n_queries, n_hits);
        $display("and %0d spare-code commands over %0d map sizes; %0d mismatches.",
                 n_unused, n_settings, mismatches);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/glos_pkg.sv
rtl/glos_ctrl.sv
rtl/glos_datapath.sv
rtl/grid_line_of_sight.sv
tb/tb_grid_line_of_sight.sv
